>>> rtl/fptb_pkg.sv
// Package for the framed periodic tick beacon: protocol constants and
// the packet descriptor passed from the front end to the back end.
// No dependencies.
package fptb_pkg;

  localparam logic [7:0] SyncIn   = 8'hAA;
  localparam logic [7:0] SyncOut  = 8'hBB;
  localparam logic [7:0] CmdSetup = 8'h01;
  localparam logic [7:0] CmdStop  = 8'h02;
  localparam logic [7:0] RespStop = 8'h03;

  localparam int unsigned PktLen = 8;
  localparam int unsigned XorLen = 7;

  localparam logic [15:0] PeriodRst = 16'd2000;
  localparam logic [15:0] ElapsedMax = 16'hFFFF;

  localparam int unsigned QueueDepth = 4;

  // One outgoing packet: stop reply or tick with its timestamp.
  typedef struct packed {
    logic        to_sender;
    logic [15:0] ts;
  } fptb_desc_t;

endpackage

>>> rtl/fptb_front.sv
// Front end: accepts bytes and ticks, frames and checks packets, keeps
// period, timestamp and elapsed count, and queues packet descriptors.
// Depends on fptb_pkg.
module fptb_front
  import fptb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        rx_last_i,
  input  logic        q_full_i,
  output logic        push_o,
  output fptb_desc_t  push_desc_o
);

  logic [3:0]  pos_q, pos_d;
  logic [7:0]  xor_q, xor_d;
  logic        sync_q, sync_d;
  logic [7:0]  code_q, code_d;
  logic [7:0]  ph_q, ph_d;
  logic [7:0]  pl_q, pl_d;
  logic [15:0] period_q, period_d;
  logic        ticking_q, ticking_d;
  logic [15:0] ts_q, ts_d;
  logic [15:0] elapsed_q, elapsed_d;

  logic        accept;
  logic        pkt_ok;
  logic [15:0] el_inc;
  logic [15:0] new_period;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign el_inc     = (elapsed_q == ElapsedMax) ? elapsed_q : elapsed_q + 16'd1;
  assign new_period = {ph_q, pl_q};

  always_comb begin
    pos_d       = pos_q;
    xor_d       = xor_q;
    sync_d      = sync_q;
    code_d      = code_q;
    ph_d        = ph_q;
    pl_d        = pl_q;
    period_d    = period_q;
    ticking_d   = ticking_q;
    ts_d        = ts_q;
    elapsed_d   = elapsed_q;
    pkt_ok      = 1'b0;
    push_o      = 1'b0;
    push_desc_o = '{to_sender: 1'b0, ts: ts_q};
    if (accept) begin
      if (cmd_i) begin
        if (ticking_q) begin
          if (el_inc >= period_q) begin
            elapsed_d = '0;
            push_o    = 1'b1;
            ts_d      = ts_q + 16'd1;
          end else begin
            elapsed_d = el_inc;
          end
        end
      end else begin
        if (pos_q < 4'(PktLen)) begin
          case (pos_q)
            4'd0:    sync_d = (rx_byte_i == SyncIn);
            4'd1:    code_d = rx_byte_i;
            4'd2:    ph_d   = rx_byte_i;
            4'd3:    pl_d   = rx_byte_i;
            default: ;
          endcase
          if (pos_q < 4'(XorLen)) begin
            xor_d = xor_q ^ rx_byte_i;
          end else begin
            pkt_ok = sync_q && (rx_byte_i == xor_q);
          end
          pos_d = pos_q + 4'd1;
        end
        if (rx_last_i) begin
          pos_d = '0;
          xor_d = '0;
          if (pkt_ok) begin
            if (code_q == CmdSetup) begin
              if (new_period != '0) begin
                period_d = new_period;
              end
              ticking_d   = 1'b1;
              elapsed_d   = '0;
              push_o      = 1'b1;
              push_desc_o = '{to_sender: 1'b0, ts: 16'd0};
              ts_d        = 16'd1;
            end else if (code_q == CmdStop) begin
              ticking_d   = 1'b0;
              push_o      = 1'b1;
              push_desc_o = '{to_sender: 1'b1, ts: 16'd0};
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      xor_q     <= '0;
      sync_q    <= 1'b0;
      code_q    <= '0;
      ph_q      <= '0;
      pl_q      <= '0;
      period_q  <= PeriodRst;
      ticking_q <= 1'b0;
      ts_q      <= '0;
      elapsed_q <= '0;
    end else begin
      pos_q     <= pos_d;
      xor_q     <= xor_d;
      sync_q    <= sync_d;
      code_q    <= code_d;
      ph_q      <= ph_d;
      pl_q      <= pl_d;
      period_q  <= period_d;
      ticking_q <= ticking_d;
      ts_q      <= ts_d;
      elapsed_q <= elapsed_d;
    end
  end

`ifndef SYNTH
  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= 4'(PktLen))
    else $error("byte position beyond saturation");

  a_elapsed_lt_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    elapsed_q < period_q)
    else $error("elapsed count reached period without a tick");
`endif

endmodule

>>> rtl/fptb_fifo.sv
// Short descriptor queue between front end and back end.
// Register array with read and write pointers. Depends on fptb_pkg.
module fptb_fifo
  import fptb_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  fptb_desc_t push_desc_i,
  output logic       full_o,
  output logic       valid_o,
  input  logic       pop_i,
  output fptb_desc_t pop_desc_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  fptb_desc_t      mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign valid_o    = (cnt_q != '0);
  assign pop_desc_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");
`endif

endmodule

>>> rtl/fptb_back.sv
// Back end: takes one descriptor at a time and sends its 8-byte packet,
// one byte per accepted output cycle. Depends on fptb_pkg.
module fptb_back
  import fptb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  fptb_desc_t q_desc_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] tx_byte_o,
  output logic       to_sender_o,
  output logic       tx_last_o
);

  logic       busy_q, busy_d;
  logic [2:0] idx_q, idx_d;
  fptb_desc_t desc_q;
  logic       last_byte;
  logic [7:0] b1;

  assign last_byte   = (idx_q == 3'(PktLen - 1));
  assign pop_o       = q_valid_i && (!busy_q || (out_ready_i && last_byte));
  assign out_valid_o = busy_q;
  assign to_sender_o = desc_q.to_sender;
  assign tx_last_o   = last_byte;
  assign b1          = desc_q.to_sender ? RespStop : 8'h00;

  always_comb begin
    case (idx_q)
      3'd0:    tx_byte_o = SyncOut;
      3'd1:    tx_byte_o = b1;
      3'd2:    tx_byte_o = desc_q.ts[15:8];
      3'd3:    tx_byte_o = desc_q.ts[7:0];
      3'd7:    tx_byte_o = SyncOut ^ b1 ^ desc_q.ts[15:8] ^ desc_q.ts[7:0];
      default: tx_byte_o = 8'h00;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (pop_o) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (busy_q && out_ready_i) begin
      if (last_byte) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      desc_q <= q_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

endmodule

>>> rtl/framed_periodic_tick_beacon_core.sv
// Framed periodic tick beacon, top level: front end, descriptor queue,
// back end. Depends on fptb_pkg, fptb_front, fptb_fifo, fptb_back.
//
// Input items (packet bytes or millisecond ticks) are taken one per cycle
// while the descriptor queue has room; each item is handled in the cycle it
// is accepted. A valid setup or stop packet, or a tick that ends a period,
// queues one packet, which the back end sends as 8 output items at one per
// cycle while the output is ready. Output bandwidth of the back end and the
// queue depth (QueueDepth packets, default 4) set when input stalls.
module framed_periodic_tick_beacon_core
  import fptb_pkg::*;
#(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_i,
  input  logic [7:0] rx_byte_i,
  input  logic       rx_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] tx_byte_o,
  output logic       to_sender_o,
  output logic       tx_last_o
);

  logic       q_full;
  logic       q_valid;
  logic       push;
  logic       pop;
  fptb_desc_t push_desc;
  fptb_desc_t pop_desc;

  fptb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .rx_byte_i   (rx_byte_i),
    .rx_last_i   (rx_last_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_desc_o (push_desc)
  );

  fptb_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (pop),
    .pop_desc_o  (pop_desc)
  );

  fptb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_desc_i    (pop_desc),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .tx_byte_o   (tx_byte_o),
    .to_sender_o (to_sender_o),
    .tx_last_o   (tx_last_o)
  );

endmodule
